// File: design/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types, command codes and constants of the voltage-current capture
// sequencer.
// ----------------------------------------------------------------------------
package vsc_pkg;

   localparam int SAMPLE_DEPTH_DEFAULT = 64;

   localparam logic [2:0] CMD_CONVERT = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_READOUT = 3'd2;
   localparam logic [2:0] CMD_CAL     = 3'd3;
   localparam logic [2:0] CMD_TOGGLE  = 3'd4;

   localparam logic [1:0] MODE_CAL   = 2'd0;
   localparam logic [1:0] MODE_TWO   = 2'd1;
   localparam logic [1:0] MODE_THREE = 2'd2;

   localparam logic [1:0] CH_REF  = 2'd0;
   localparam logic [1:0] CH_VOLT = 2'd1;
   localparam logic [1:0] CH_CURR = 2'd2;
   localparam logic [1:0] CH_GATE = 2'd3;

   localparam logic [15:0] MID_SCALE = 16'd16384;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] adc_word;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [5:0]         pair_index;
      logic signed [15:0] load_voltage;
      logic signed [15:0] load_current;
      logic               last;
      logic [14:0]        gate_level;
      logic [6:0]         captured_count;
      logic [1:0]         mode_now;
      logic signed [15:0] offset_now;
   } rsp_type;

   typedef struct packed {
      logic clear_we;
      logic latch_req;
      logic exec;
      logic start_readout;
      logic idx_clear;
      logic idx_inc;
      logic acc_clear;
      logic acc_add;
      logic set_cal;
      logic capture_pair;
      logic load_status;
      logic load_pair;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] req_cmd;
      logic       mode_cal;
      logic       idx_last;
   } dp_sts_type;

endpackage

// File: design/vsc_ram.sv
// ----------------------------------------------------------------------------
// vsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = vsc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/vsc_datapath.sv
// ----------------------------------------------------------------------------
// vsc_datapath
// Sequencer state, sample stores, offset accumulator and result register.
// ----------------------------------------------------------------------------
module vsc_datapath #(
   parameter int SAMPLE_DEPTH = vsc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vsc_pkg::req_type      req_data,
   input  vsc_pkg::ctrl_cmd_type cmd,
   output vsc_pkg::dp_sts_type   sts,
   output vsc_pkg::rsp_type      rsp_data
);

   localparam int AW    = $clog2(SAMPLE_DEPTH);
   localparam int CW    = $clog2(SAMPLE_DEPTH + 1);
   localparam int SW    = 17 + AW;
   localparam int SHIFT = $clog2(SAMPLE_DEPTH + 1) - 1;

   vsc_pkg::req_type req_ff, req_in;
   logic [1:0]          channel_ff, channel_in;
   logic [14:0]         ref_ff, ref_in;
   logic [14:0]         gate_ff, gate_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [15:0]         offset_ff, offset_in;
   logic [1:0]          mode_ff, mode_in;
   logic                sent_ff, sent_in;
   logic                sub_ff, sub_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [15:0]         vhold_ff, vhold_in;
   logic [15:0]         chold_ff, chold_in;
   vsc_pkg::rsp_type    rsp_ff, rsp_in;

   logic [14:0] h;
   logic        room;
   logic        idx_last;
   logic        conv;
   logic        volt_we, cur_we;
   logic [AW-1:0] volt_waddr, cur_waddr;
   logic [15:0] volt_wdata, cur_wdata;
   logic [15:0] volt_rdata, cur_rdata;
   logic [15:0] cur_wb;

   assign h        = req_ff.adc_word[15:1];
   assign room     = count_ff < CW'(SAMPLE_DEPTH);
   assign idx_last = idx_ff == AW'(SAMPLE_DEPTH - 1);
   assign conv     = cmd.exec && (req_ff.cmd == vsc_pkg::CMD_CONVERT) && room;
   assign cur_wb   = cur_rdata - offset_ff;

   assign volt_we    = cmd.clear_we || (conv && channel_ff == vsc_pkg::CH_VOLT);
   assign volt_waddr = cmd.clear_we ? idx_ff : count_ff[AW-1:0];
   assign volt_wdata = cmd.clear_we ? 16'd0 : ({1'b0, h} - {1'b0, ref_ff});

   assign cur_we    = cmd.clear_we || (conv && channel_ff == vsc_pkg::CH_CURR)
                      || (cmd.capture_pair && sub_ff);
   assign cur_waddr = cmd.exec ? count_ff[AW-1:0] : idx_ff;

   always_comb begin
      priority if (cmd.clear_we) begin
         cur_wdata = 16'd0;
      end else if (cmd.exec) begin
         cur_wdata = {1'b0, h} - vsc_pkg::MID_SCALE;
      end else begin
         cur_wdata = cur_wb;
      end
   end

   vsc_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_volt_ram (
      .clock (clock),
      .we    (volt_we),
      .waddr (volt_waddr),
      .wdata (volt_wdata),
      .raddr (idx_ff),
      .rdata (volt_rdata)
   );

   vsc_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_cur_ram (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (idx_ff),
      .rdata (cur_rdata)
   );

   always_comb begin
      req_in     = cmd.latch_req ? req_data : req_ff;
      channel_in = channel_ff;
      ref_in     = ref_ff;
      gate_in    = gate_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      mode_in    = mode_ff;
      sent_in    = sent_ff;
      sub_in     = sub_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      vhold_in   = vhold_ff;
      chold_in   = chold_ff;
      rsp_in     = rsp_ff;

      if (cmd.exec) begin
         unique case (req_ff.cmd)
            vsc_pkg::CMD_CONVERT: begin
               channel_in = channel_ff + 2'd1;
               unique case (channel_ff)
                  vsc_pkg::CH_REF:  ref_in = h;
                  vsc_pkg::CH_VOLT: ;
                  vsc_pkg::CH_CURR: begin
                     if (room) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  vsc_pkg::CH_GATE: gate_in = h;
               endcase
            end
            vsc_pkg::CMD_START: begin
               if (sent_ff) begin
                  count_in = '0;
                  sent_in  = 1'b0;
               end
            end
            vsc_pkg::CMD_CAL: mode_in = vsc_pkg::MODE_CAL;
            vsc_pkg::CMD_TOGGLE: begin
               mode_in = (mode_ff == vsc_pkg::MODE_TWO) ? vsc_pkg::MODE_THREE
                                                         : vsc_pkg::MODE_TWO;
            end
            default: ;
         endcase
      end

      if (cmd.start_readout) begin
         sent_in = 1'b1;
         sub_in  = mode_ff == vsc_pkg::MODE_TWO;
      end

      if (cmd.set_cal) begin
         offset_in = 16'(acc_ff >>> SHIFT);
         mode_in   = vsc_pkg::MODE_TWO;
      end

      priority if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else begin
         idx_in = idx_ff;
      end

      priority if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + SW'(signed'(cur_rdata));
      end else begin
         acc_in = acc_ff;
      end

      if (cmd.capture_pair) begin
         vhold_in = volt_rdata;
         chold_in = sub_ff ? cur_wb : cur_rdata;
      end

      if (cmd.load_status || cmd.load_pair) begin
         rsp_in.kind           = cmd.load_pair;
         rsp_in.pair_index     = cmd.load_pair ? 6'(idx_ff) : 6'd0;
         rsp_in.load_voltage   = cmd.load_pair ? vhold_ff : 16'd0;
         rsp_in.load_current   = cmd.load_pair ? chold_ff : 16'd0;
         rsp_in.last           = cmd.load_status || idx_last;
         rsp_in.gate_level     = gate_ff;
         rsp_in.captured_count = 7'(count_ff);
         rsp_in.mode_now       = mode_ff;
         rsp_in.offset_now     = offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= vsc_pkg::CH_CURR;
         ref_ff     <= '0;
         gate_ff    <= '0;
         count_ff   <= '0;
         offset_ff  <= '0;
         mode_ff    <= vsc_pkg::MODE_TWO;
         sent_ff    <= 1'b0;
         sub_ff     <= 1'b0;
         idx_ff     <= '0;
      end else begin
         channel_ff <= channel_in;
         ref_ff     <= ref_in;
         gate_ff    <= gate_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         mode_ff    <= mode_in;
         sent_ff    <= sent_in;
         sub_ff     <= sub_in;
         idx_ff     <= idx_in;
      end
      req_ff   <= req_in;
      acc_ff   <= acc_in;
      vhold_ff <= vhold_in;
      chold_ff <= chold_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.req_cmd  = req_ff.cmd;
   assign sts.mode_cal = mode_ff == vsc_pkg::MODE_CAL;
   assign sts.idx_last = idx_last;
   assign rsp_data     = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SAMPLE_DEPTH))
      else $error("sample count above store depth");

   a_readout_sent: assert property (@(posedge clock) disable iff (reset)
      cmd.start_readout |=> sent_ff)
      else $error("readout did not mark sweep sent");

   a_cal_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.set_cal |=> (mode_ff == vsc_pkg::MODE_TWO))
      else $error("calibration did not return to two-terminal mode");

endmodule

// File: design/vsc_ctrl.sv
// ----------------------------------------------------------------------------
// vsc_ctrl
// Controller: clearing pass, command dispatch, offset pass and pair readout.
// ----------------------------------------------------------------------------
module vsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  vsc_pkg::dp_sts_type   sts,
   output vsc_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_STATUS,
      ST_SUM_ADDR,
      ST_SUM_ACC,
      ST_SUM_DONE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.req_cmd == vsc_pkg::CMD_READOUT) begin
               cmd.start_readout = 1'b1;
               cmd.idx_clear     = 1'b1;
               cmd.acc_clear     = 1'b1;
               state_in          = sts.mode_cal ? ST_SUM_ADDR : ST_RD_ADDR;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (rsp_free) begin
               cmd.load_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SUM_ADDR: state_in = ST_SUM_ACC;
         ST_SUM_ACC: begin
            cmd.acc_add = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_SUM_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SUM_ADDR;
            end
         end
         ST_SUM_DONE: begin
            cmd.set_cal = 1'b1;
            state_in    = ST_RD_ADDR;
         end
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            cmd.capture_pair = 1'b1;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               cmd.load_pair = 1'b1;
               if (sts.idx_last) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RD_ADDR;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.load_status || cmd.load_pair) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_pair) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result waits");

endmodule

// File: design/vi_sample_capture_sequencer.sv
// ----------------------------------------------------------------------------
// vi_sample_capture_sequencer
// Voltage-current capture for one sweep: four-step converter sequencer,
// sample stores, offset calibration and pair readout.
//
//   channel  direction  payload            handshake
//   req_     in         vsc_pkg::req_type  req_valid / req_ready
//   rsp_     out        vsc_pkg::rsp_type  rsp_valid / rsp_ready
//
// After reset a clearing pass zeroes every address of both stores;
// req_ready stays low until it is done.
// A non-readout item is latched on accept, executed in the dispatch state and
// its result loaded in the status state, which waits on the result register;
// the controller then returns to idle for the next item. Readout goes through
// store read, capture and emit for each pair; calibration mode first runs an
// offset pass over the current store.
// A stalled rsp_ready holds the result register; the next item is taken
// while the last result still waits.
// ----------------------------------------------------------------------------
module vi_sample_capture_sequencer #(
   parameter int SAMPLE_DEPTH = vsc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vsc_pkg::rsp_type rsp_data
);

   vsc_pkg::ctrl_cmd_type cmd;
   vsc_pkg::dp_sts_type   sts;

   vsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vsc_datapath #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
